FILE: hw/rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// Types, constants and the Paeth predictor shared by the row filter blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

  localparam int SUM_W = 21;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes (byte address 4*i)
  localparam logic REG_FILTER = 1'b0;
  localparam logic REG_BPP    = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE      = 3'd0,
    FILT_SUB       = 3'd1,
    FILT_UP        = 3'd2,
    FILT_AVG       = 3'd3,
    FILT_PAETH     = 3'd4,
    FILT_AVG_FIRST = 3'd5,
    FILT_PAETH_FIRST = 3'd6
  } filt_t;

  // one classified byte between front and back
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] above;
    logic [7:0] left;
    logic [7:0] upper_left;
    logic       row_start;
    logic       row_end;
  } q_entry_t;

  // ties go to a, then b, then c
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/prf_front.sv
// ----------------------------------------------------------------------------
// prf_front
// Accepts raw bytes, keeps the neighbor history and picks a and c.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_front import prf_pkg::*; #(
  parameter int MAX_BPP = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] cur_byte,
  input  wire logic [7:0] above_byte,
  input  wire logic       row_start,
  input  wire logic       row_end,
  input  wire logic [3:0] bytes_per_pixel,
  input  wire logic       full,
  output logic            push,
  output q_entry_t        push_data
);

  localparam int IDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  logic [7:0] left_hist  [MAX_BPP];
  logic [7:0] upper_hist [MAX_BPP];

  logic [4:0]       pix_dist;
  logic [4:0]       dist_m1;
  logic [IDX_W-1:0] sel;

  always_comb begin
    if (bytes_per_pixel == 4'd0) begin
      pix_dist = 5'd1;
    end else if ({1'b0, bytes_per_pixel} > 5'(MAX_BPP)) begin
      pix_dist = 5'(MAX_BPP);
    end else begin
      pix_dist = {1'b0, bytes_per_pixel};
    end
    dist_m1 = pix_dist - 5'd1;
    sel     = dist_m1[IDX_W-1:0];
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    push_data.cur        = cur_byte;
    push_data.above      = above_byte;
    push_data.left       = row_start ? 8'd0 : left_hist[sel];
    push_data.upper_left = row_start ? 8'd0 : upper_hist[sel];
    push_data.row_start  = row_start;
    push_data.row_end    = row_end;
  end

  // newest first; a row start flushes the older entries
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_BPP; k++) begin
        left_hist[k]  <= 8'd0;
        upper_hist[k] <= 8'd0;
      end
    end else if (push) begin
      left_hist[0]  <= cur_byte;
      upper_hist[0] <= above_byte;
      for (int k = 1; k < MAX_BPP; k++) begin
        left_hist[k]  <= row_start ? 8'd0 : left_hist[k-1];
        upper_hist[k] <= row_start ? 8'd0 : upper_hist[k-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prf_queue.sv
// ----------------------------------------------------------------------------
// prf_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_queue import prf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: hw/rtl/prf_back.sv
// ----------------------------------------------------------------------------
// prf_back
// Predicts, forms the residual and the saturating row sum; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_back import prf_pkg::*; #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        filter_type,
  input  wire q_entry_t          head,
  input  wire logic              not_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [7:0]      filtered_byte,
  output logic [SUM_W-1:0]       row_sum,
  output logic                   row_done
);

  localparam longint unsigned RAW_BOUND = 64'(MAX_ROW_BYTES) * 64'd128;
  localparam logic [SUM_W-1:0] SUM_BOUND =
    (RAW_BOUND > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(RAW_BOUND);

  logic [SUM_W-1:0] sum_acc;
  logic [7:0]       pred;
  logic [8:0]       avg_sum;
  logic [7:0]       res;
  logic [8:0]       mag;
  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   total;
  logic [SUM_W-1:0] sum_next;

  // output register doubles as the skid stage
  assign pop = not_empty && (!out_valid || !out_stall);

  always_comb begin
    avg_sum = {1'b0, head.left} + {1'b0, head.above};
    case (filt_t'(filter_type))
      FILT_SUB:         pred = head.left;
      FILT_UP:          pred = head.above;
      FILT_AVG:         pred = avg_sum[8:1];
      FILT_PAETH:       pred = paeth(head.left, head.above, head.upper_left);
      FILT_AVG_FIRST:   pred = {1'b0, head.left[7:1]};
      FILT_PAETH_FIRST: pred = head.left;
      default:          pred = 8'd0;
    endcase
    res      = head.cur - pred;
    mag      = res[7] ? (9'd256 - {1'b0, res}) : {1'b0, res};
    base     = head.row_start ? '0 : sum_acc;
    total    = {1'b0, base} + (SUM_W+1)'(mag);
    sum_next = (total > {1'b0, SUM_BOUND}) ? SUM_BOUND : total[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        sum_acc   <= sum_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      filtered_byte <= $signed(res);
      row_sum       <= sum_next;
      row_done      <= head.row_end;
    end
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_sum <= SUM_BOUND)
    else $error("row sum above bound");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.row_start) |=> row_sum <= SUM_W'(128))
    else $error("row start did not clear sum");

endmodule

`default_nettype wire

FILE: hw/rtl/png_row_filter_encoder.sv
// ----------------------------------------------------------------------------
// png_row_filter_encoder
// PNG scanline filter, one byte per transfer, with a saturating row sum.
// ----------------------------------------------------------------------------
// Path from input transfer to result valid: the queue, then the output reg.
// Throughput: one byte per cycle while out_stall is low; the 2-entry queue and the output register
//   let front and back stall independently.
// Reset (rst, synchronous): filter_type = none, bytes_per_pixel = 1,
//   neighbor history and row sum cleared, queue and output emptied.
`default_nettype none

module png_row_filter_encoder import prf_pkg::*; #(
  parameter int MAX_BPP       = 8,
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   cur_byte,
  input  wire logic [7:0]   above_byte,
  input  wire logic         row_start,
  input  wire logic         row_end,
  // output channel
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [7:0] filtered_byte,
  output logic [SUM_W-1:0]  row_sum,
  output logic              row_done
);

  logic [2:0] filter_type;
  logic [3:0] bytes_per_pixel;
  logic       cfg_write;

  logic     push;
  logic     full;
  logic     pop;
  logic     not_empty;
  q_entry_t push_data;
  q_entry_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BPP) ? {28'd0, bytes_per_pixel}
                                           : {29'd0, filter_type};

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_type     <= FILT_NONE;
      bytes_per_pixel <= 4'd1;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FILTER) begin
        filter_type <= pwdata[2:0];
      end else begin
        bytes_per_pixel <= pwdata[3:0];
      end
    end
  end

  prf_front #(
    .MAX_BPP (MAX_BPP)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cur_byte        (cur_byte),
    .above_byte      (above_byte),
    .row_start       (row_start),
    .row_end         (row_end),
    .bytes_per_pixel (bytes_per_pixel),
    .full            (full),
    .push            (push),
    .push_data       (push_data)
  );

  prf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  prf_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .filter_type   (filter_type),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .filtered_byte (filtered_byte),
    .row_sum       (row_sum),
    .row_done      (row_done)
  );

endmodule

`default_nettype wire

FILE: dv/png_row_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_row_filter_checker
// Tracks register writes and input transfers, predicts each filtered byte and
// row sum, and compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module png_row_filter_checker import prf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  input  wire logic             pready,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [7:0]       cur_byte,
  input  wire logic [7:0]       above_byte,
  input  wire logic             row_start,
  input  wire logic             row_end,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic signed [7:0] filtered_byte,
  input  wire logic [SUM_W-1:0] row_sum,
  input  wire logic             row_done,
  output int                    errors,
  output int                    pending
);

  localparam int HIST_DEPTH = 8;
  localparam int ROW_SUM_CAP = 8192 * 128;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic signed [7:0] residual;
    logic [SUM_W-1:0]  sum;
    logic              done;
  } row_result_t;

  row_result_t      residual_q[$];
  logic [2:0]       filt_mode;
  logic [3:0]       pixel_bytes;
  logic [7:0]       left_hist [HIST_DEPTH];
  logic [7:0]       upleft_hist [HIST_DEPTH];
  logic [SUM_W-1:0] sum_acc;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // ties resolve to a, then b, then c
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int pa;
    int pb;
    int pc;
    pa = magnitude(int'(b) - int'(c));
    pb = magnitude(int'(a) - int'(c));
    pc = magnitude(int'(a) + int'(b) - 2 * int'(c));
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  function automatic logic [7:0] predictor(input logic [2:0] mode, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
    case (mode)
      FILT_SUB:         return a;
      FILT_UP:          return b;
      FILT_AVG:         return 8'((int'(a) + int'(b)) >> 1);
      FILT_PAETH:       return paeth_pick(a, b, c);
      FILT_AVG_FIRST:   return a >> 1;
      FILT_PAETH_FIRST: return paeth_pick(a, 8'd0, 8'd0);
      default:          return 8'd0;
    endcase
  endfunction

  task automatic predict_residual(input logic [7:0] cur, input logic [7:0] above,
                                  input logic first, input logic last);
    int          left_dist;
    int          mag;
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  res;
    row_result_t r;
    left_dist = (pixel_bytes == 0) ? 1 :
                (int'(pixel_bytes) > HIST_DEPTH) ? HIST_DEPTH : int'(pixel_bytes);
    if (first) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        left_hist[k] = 8'd0;
        upleft_hist[k] = 8'd0;
      end
      sum_acc = '0;
    end
    a = left_hist[left_dist-1];
    c = upleft_hist[left_dist-1];
    res = cur - predictor(filt_mode, a, above, c);
    mag = res[7] ? 256 - int'(res) : int'(res);
    if (ROW_SUM_CAP - int'(sum_acc) < mag) begin
      sum_acc = SUM_W'(ROW_SUM_CAP);
    end else begin
      sum_acc = sum_acc + SUM_W'(mag);
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0] = cur;
    upleft_hist[0] = above;
    r.residual = res;
    r.sum = sum_acc;
    r.done = last;
    residual_q.push_back(r);
  endtask

  always @(posedge clk) begin
    row_result_t exp_r;
    if (rst) begin
      filt_mode = FILT_NONE;
      pixel_bytes = 4'd1;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        left_hist[k] = 8'd0;
        upleft_hist[k] = 8'd0;
      end
      sum_acc = '0;
      residual_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_FILTER: filt_mode = pwdata[2:0];
          REG_BPP:    pixel_bytes = pwdata[3:0];
          default:    ;
        endcase
      end
      // compare before queuing this edge's input transfer
      if (out_valid && !out_stall) begin
        if (residual_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT) begin
            $display("%0t: unexpected result transfer: residual %0d sum %0d done %0b",
                     $time, filtered_byte, row_sum, row_done);
          end
        end else begin
          exp_r = residual_q.pop_front();
          if (filtered_byte !== exp_r.residual || row_sum !== exp_r.sum ||
              row_done !== exp_r.done) begin
            errors++;
            if (errors <= SHOW_LIMIT) begin
              $display("%0t: mismatch exp/act: residual %0d/%0d sum %0d/%0d done %0b/%0b",
                       $time, exp_r.residual, filtered_byte, exp_r.sum, row_sum,
                       exp_r.done, row_done);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_residual(cur_byte, above_byte, row_start, row_end);
      end
    end
    pending = residual_q.size();
  end

endmodule

FILE: dv/tb_png_row_filter_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_row_filter_encoder
// Drives byte rows and register settings into the row filter under several
// idle and stall mixes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_png_row_filter_encoder;
  import prf_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int BYTES_PER_SETTING = 28;
  localparam logic [3:0] DIR_BPP [8] = '{4'd1, 4'd1, 4'd2, 4'd1, 4'd3, 4'd8, 4'd15, 4'd0};
  localparam int IDLE_PCT [4] = '{0, 59, 0, 32};
  localparam int STALL_PCT [4] = '{0, 0, 59, 32};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        cur_byte = '0;
  logic [7:0]        above_byte = '0;
  logic              row_start = 1'b0;
  logic              row_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] filtered_byte;
  logic [SUM_W-1:0]  row_sum;
  logic              row_done;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int rows_sent = 0;
  int settings_applied = 0;

  always #5 clk = ~clk;

  png_row_filter_encoder u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .cur_byte, .above_byte, .row_start, .row_end,
    .out_valid, .out_stall, .filtered_byte, .row_sum, .row_done
  );

  png_row_filter_checker u_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .cur_byte, .above_byte, .row_start, .row_end,
    .out_valid, .out_stall, .filtered_byte, .row_sum, .row_done,
    .errors, .pending
  );

  always @(negedge clk) begin
    out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input logic regsel, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {regsel, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] cur, input logic [7:0] above,
                           input logic first, input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur_byte = cur;
    above_byte = above;
    row_start = first;
    row_end = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
    if (last) begin
      rows_sent++;
    end
  endtask

  // settle: all results back, then idle clocks before the next register write
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [2:0] filt, input logic [3:0] bpp);
    drain();
    reg_write(REG_FILTER, 32'(filt));
    reg_write(REG_BPP, 32'(bpp));
    settings_applied++;
  endtask

  // small value set makes Paeth ties and wraparound likely
  function automatic logic [7:0] edge_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic send_row(input int len);
    logic       broken;
    logic       flat;
    logic [7:0] c;
    logic [7:0] a;
    broken = ($urandom_range(9) == 0);
    flat = ($urandom_range(3) == 0);
    for (int k = 0; k < len; k++) begin
      c = flat ? edge_byte() : 8'($urandom);
      a = flat ? edge_byte() : 8'($urandom);
      if (broken) begin
        send_byte(c, a, 1'($urandom), 1'($urandom));
      end else begin
        send_byte(c, a, k == 0, k == len - 1);
      end
    end
  endtask

  initial begin
    int         setting;
    int         base;
    logic [2:0] filt;
    logic [3:0] bpp;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // every mode, odd distances, and rows that carry on without a start mark
    for (int m = 0; m < 8; m++) begin
      apply_setting(3'(m), DIR_BPP[m]);
      send_byte(8'hFF, 8'h00, !m[0], 1'b0);
      send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
      send_byte(8'h80, 8'h7F, 1'b0, 1'b1);
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      for (int s = 0; s < 3; s++) begin
        setting = 3 * p + s;
        filt = (setting < 8) ? 3'(setting) : 3'($urandom_range(7));
        case (setting)
          1:       bpp = 4'd8;
          2:       bpp = 4'd0;
          3:       bpp = 4'd15;
          4:       bpp = 4'd1;
          default: bpp = 4'($urandom_range(1, 8));
        endcase
        apply_setting(filt, bpp);
        base = bytes_sent;
        while (bytes_sent - base < BYTES_PER_SETTING) begin
          send_row($urandom_range(1, 24));
        end
      end
    end

    drain();
    $display("Covered %0d bytes, %0d row ends, %0d register settings, all modes",
             bytes_sent, rows_sent, settings_applied);
    $display("and distances, rows without start marks, and four idle/stall mixes");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
